// File: rtl/array_max_priority_queue_defines.svh
// Assertion macros for the array max-priority queue.
// Included by the RTL files that carry assertions; depends on clk and rst in scope.
`ifndef ARRAY_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define ARRAY_MAX_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define APQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define APQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/apq_pkg.sv
// Package for the array max-priority queue: payload structs, codes and defaults.
// Depends on nothing; used by every RTL file of the block.
`default_nettype none

package apq_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int DATA_W           = 32;
  localparam int ENTRY_COUNT_W    = 7;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_PEEK    = 2'd2,
    OP_MODIFY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

  typedef struct packed {
    op_t                opcode;
    logic [DATA_W-1:0]  element;
    logic [DATA_W-1:0]  priority_req;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0]         out_element;
    logic [DATA_W-1:0]         out_priority;
    status_t                   status;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
  } out_t;

  // One stored queue entry.
  typedef struct packed {
    logic [DATA_W-1:0] elem;
    logic [DATA_W-1:0] prio;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/apq_entry_ram.sv
// Entry store of the array max-priority queue: one write port, one registered read port.
// Depends on apq_pkg for the entry type.
`default_nettype none

module apq_entry_ram #(
  parameter int DEPTH = apq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire apq_pkg::entry_t            wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output apq_pkg::entry_t                 rd_data
);

  apq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/array_max_priority_queue.sv
// Array max-priority queue: entries kept unsorted in insertion order in one entry RAM.
// Insert, and extract, peek or modify of an empty queue, go straight to the result state;
// peek and modify scan the entries, and extract scans and then moves later entries down;
// the registered RAM read port visits one entry per cycle while scanning and shifting.
// One operation at a time: the next transfer in is taken the cycle after the result is loaded.
// Reset (rst, synchronous, active high) empties the queue; the RAM contents are not cleared.
`default_nettype none

`include "array_max_priority_queue_defines.svh"

module array_max_priority_queue #(
  parameter int CAPACITY = apq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire apq_pkg::in_t  req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output apq_pkg::out_t      rsp
);

  // Address width for the entries, and a count width that can also hold CAPACITY itself.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE       = CW'(1);

  // Control state.
  apq_pkg::state_t state, state_next;
  logic [CW-1:0]   count, count_next;
  logic            rsp_valid_next;

  // Read sequencing: rd_ptr is the next address to issue, rd_live marks that the
  // RAM output holds the entry at rd_idx in this cycle.
  logic [CW-1:0]   rd_ptr, rd_ptr_next;
  logic            rd_live, rd_live_next;
  logic [AW-1:0]   rd_idx, rd_idx_next;

  // Payload registers: the operation being worked on, the best entry so far and the result.
  apq_pkg::in_t    req_q, req_q_next;
  apq_pkg::entry_t best, best_next;
  logic [AW-1:0]   best_pos, best_pos_next;
  logic [apq_pkg::DATA_W-1:0] res_elem, res_elem_next;
  logic [apq_pkg::DATA_W-1:0] res_prio, res_prio_next;
  apq_pkg::status_t           res_status, res_status_next;
  apq_pkg::out_t              rsp_next;

  // Entry RAM ports.
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  apq_pkg::entry_t wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  apq_pkg::entry_t rd_data;

  // Helpers for the scan.
  logic            cand_better;
  apq_pkg::entry_t best_sel;
  logic [AW-1:0]   best_pos_sel;
  logic            last_entry;
  logic            issue;

  apq_entry_ram #(
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The first entry always takes the lead; a later one only with a strictly higher
  // priority, so that ties stay with the oldest entry.
  assign cand_better  = (rd_idx == '0) || (rd_data.prio > best.prio);
  assign best_sel     = cand_better ? rd_data : best;
  assign best_pos_sel = cand_better ? rd_idx : best_pos;
  assign last_entry   = rd_live && (CW'(rd_idx) == count - ONE);
  assign issue        = rd_ptr < count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= apq_pkg::S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      rd_live   <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
      rd_live   <= rd_live_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr     <= rd_ptr_next;
    rd_idx     <= rd_idx_next;
    req_q      <= req_q_next;
    best       <= best_next;
    best_pos   <= best_pos_next;
    res_elem   <= res_elem_next;
    res_prio   <= res_prio_next;
    res_status <= res_status_next;
    rsp        <= rsp_next;
  end

  // Sequencer. Reads and writes never meet at one entry in one cycle: a modify writes
  // the entry just read, and a shift writes one place below the entry just read while
  // the next read goes one place above it, so no forwarding path is needed.
  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_ptr_next     = rd_ptr;
    rd_live_next    = 1'b0;
    rd_idx_next     = rd_idx;
    req_q_next      = req_q;
    best_next       = best;
    best_pos_next   = best_pos;
    res_elem_next   = res_elem;
    res_prio_next   = res_prio;
    res_status_next = res_status;
    rsp_next        = rsp;
    rsp_valid_next  = rsp_valid && rsp_stall;
    req_stall       = (state != apq_pkg::S_IDLE);
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;
    rd_en           = 1'b0;
    rd_addr         = '0;

    unique case (state)
      apq_pkg::S_IDLE: begin
        if (req_valid) begin
          req_q_next      = req;
          res_elem_next   = '0;
          res_prio_next   = '0;
          res_status_next = apq_pkg::ST_OK;
          rd_ptr_next     = '0;
          unique case (req.opcode)
            apq_pkg::OP_INSERT: begin
              state_next = apq_pkg::S_RESP;
              if (count == CAP_COUNT) begin
                res_status_next = apq_pkg::ST_FULL;
              end else begin
                wr_en        = 1'b1;
                wr_addr      = count[AW-1:0];
                wr_data.elem = req.element;
                wr_data.prio = req.priority_req;
                count_next   = count + ONE;
              end
            end
            apq_pkg::OP_EXTRACT, apq_pkg::OP_PEEK: begin
              if (count == '0) begin
                res_status_next = apq_pkg::ST_EMPTY;
                state_next      = apq_pkg::S_RESP;
              end else begin
                state_next = apq_pkg::S_SCAN;
              end
            end
            apq_pkg::OP_MODIFY: begin
              if (count == '0) begin
                res_status_next = apq_pkg::ST_NOTFOUND;
                state_next      = apq_pkg::S_RESP;
              end else begin
                state_next = apq_pkg::S_SCAN;
              end
            end
          endcase
        end
      end

      apq_pkg::S_SCAN: begin
        if (issue) begin
          rd_en        = 1'b1;
          rd_addr      = rd_ptr[AW-1:0];
          rd_ptr_next  = rd_ptr + ONE;
          rd_live_next = 1'b1;
          rd_idx_next  = rd_ptr[AW-1:0];
        end
        if (rd_live) begin
          if (req_q.opcode == apq_pkg::OP_MODIFY) begin
            if (rd_data.elem == req_q.element) begin
              wr_en           = 1'b1;
              wr_addr         = rd_idx;
              wr_data.elem    = rd_data.elem;
              wr_data.prio    = req_q.priority_req;
              res_status_next = apq_pkg::ST_OK;
              rd_live_next    = 1'b0;
              state_next      = apq_pkg::S_RESP;
            end else if (last_entry) begin
              res_status_next = apq_pkg::ST_NOTFOUND;
              state_next      = apq_pkg::S_RESP;
            end
          end else begin
            best_next     = best_sel;
            best_pos_next = best_pos_sel;
            if (last_entry) begin
              res_elem_next   = best_sel.elem;
              res_prio_next   = best_sel.prio;
              res_status_next = apq_pkg::ST_OK;
              if (req_q.opcode == apq_pkg::OP_PEEK) begin
                state_next = apq_pkg::S_RESP;
              end else if (CW'(best_pos_sel) == count - ONE) begin
                // The maximum is the newest entry: nothing to move.
                count_next = count - ONE;
                state_next = apq_pkg::S_RESP;
              end else begin
                rd_ptr_next  = CW'(best_pos_sel) + ONE;
                rd_live_next = 1'b0;
                state_next   = apq_pkg::S_SHIFT;
              end
            end
          end
        end
      end

      apq_pkg::S_SHIFT: begin
        // Each later entry moves down one place, one entry per cycle.
        if (issue) begin
          rd_en        = 1'b1;
          rd_addr      = rd_ptr[AW-1:0];
          rd_ptr_next  = rd_ptr + ONE;
          rd_live_next = 1'b1;
          rd_idx_next  = rd_ptr[AW-1:0];
        end
        if (rd_live) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx - AW'(1);
          wr_data = rd_data;
          if (last_entry) begin
            count_next = count - ONE;
            state_next = apq_pkg::S_RESP;
          end
        end
      end

      apq_pkg::S_RESP: begin
        // The result goes out once the output register is free or being emptied.
        if (!rsp_valid || !rsp_stall) begin
          rsp_next.out_element  = res_elem;
          rsp_next.out_priority = res_prio;
          rsp_next.status       = res_status;
          rsp_next.entry_count  = apq_pkg::ENTRY_COUNT_W'(count);
          rsp_valid_next        = 1'b1;
          state_next            = apq_pkg::S_IDLE;
        end
      end
    endcase
  end

  // The stored count stays within the capacity and moves by at most one per cycle.
  `APQ_ASSERT_SAME(a_count_range, 1'b1, count <= CAP_COUNT, "entry count above capacity")
  `APQ_ASSERT_NEXT(a_count_step, 1'b1,
                   (count == $past(count)) || (count == $past(count) + ONE) ||
                   (count + ONE == $past(count)), "entry count jumped")
  // Scanning and shifting only ever run over a non-empty queue.
  `APQ_ASSERT_SAME(a_walk_nonempty, (state == apq_pkg::S_SCAN) || (state == apq_pkg::S_SHIFT),
                   count != '0, "walk over an empty queue")
  // Every RAM write lands at or below the current fill level.
  `APQ_ASSERT_SAME(a_write_in_range, wr_en, CW'(wr_addr) <= count, "entry write beyond fill level")

endmodule

`default_nettype wire
